/* sv/gso_pkg.sv */
// shared widths, latencies and helpers for the 3x3 gram-schmidt orthonormalizer
package gso_pkg;

  localparam int EW       = 32;   // matrix entry width, q3.28
  localparam int FRAC     = 28;   // fraction bits of an entry
  localparam int PCAP_LOG = 40;   // projection magnitude cap is 2^40
  localparam int PW       = PCAP_LOG + 2;  // signed projection width
  localparam int XW       = 44;   // width of the orthogonalizing sums

  // fixed pipeline depths of the sub-units
  localparam int PROJ_LAT  = 46;
  localparam int NORM_LAT  = 64;
  localparam int TOTAL_LAT = 2 * (PROJ_LAT + 1) + NORM_LAT + 1;

  typedef logic [EW-1:0] elem_t;
  typedef elem_t [2:0] vec_t;      // one column, index is the row
  typedef logic [PW-1:0] proj_t;
  typedef proj_t [2:0] pvec_t;
  typedef logic [XW-1:0] wide_t;
  typedef wide_t [2:0] wvec_t;

  function automatic wide_t sxe(input elem_t x);
    return {{(XW-EW){x[EW-1]}}, x};
  endfunction

  function automatic wide_t sxp(input proj_t x);
    return {{(XW-PW){x[PW-1]}}, x};
  endfunction

  function automatic elem_t sat32(input wide_t x);
    logic signed [XW-1:0] s;
    s = $signed(x);
    if (s > $signed(sxe({1'b0, {(EW-1){1'b1}}}))) begin
      return {1'b0, {(EW-1){1'b1}}};
    end else if (s < $signed(sxe({1'b1, {(EW-1){1'b0}}}))) begin
      return {1'b1, {(EW-1){1'b0}}};
    end else begin
      return x[EW-1:0];
    end
  endfunction

endpackage

/* sv/gram_schmidt_3x3_orthonormalizer_unit.sv */
// 3x3 classical gram-schmidt orthonormalizer, top level
//
// usage:
//   drive the nine q3.28 entries m00..m22 and raise start for one cycle;
//   the beat is taken at a rising edge where start is high and busy low.
//   busy is only high during reset, so a new matrix may follow every cycle.
//   once a matrix has passed the pipeline, done is high for one cycle and
//   q00..q22 and degenerate carry that matrix's orthonormal result.
//   results leave in the order the matrices arrived, one per cycle at most.
//   the pipeline holds two projection passes, each dominated by the
//   41-stage projection dividers, then normalization (32-stage square
//   root, 29-stage divider).
//   three projection units and three normalizers each run three row lanes.
//   reset clears the in-flight marks: nothing accepted before it comes out.
//   the receiver cannot stall; done is a pure strobe.
module gram_schmidt_3x3_orthonormalizer_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   m00,
  input  logic signed [31:0]   m01,
  input  logic signed [31:0]   m02,
  input  logic signed [31:0]   m10,
  input  logic signed [31:0]   m11,
  input  logic signed [31:0]   m12,
  input  logic signed [31:0]   m20,
  input  logic signed [31:0]   m21,
  input  logic signed [31:0]   m22,
  output logic                 done,
  output logic signed [31:0]   q00,
  output logic signed [31:0]   q01,
  output logic signed [31:0]   q02,
  output logic signed [31:0]   q10,
  output logic signed [31:0]   q11,
  output logic signed [31:0]   q12,
  output logic signed [31:0]   q20,
  output logic signed [31:0]   q21,
  output logic signed [31:0]   q22,
  output logic                 degenerate
);
  import gso_pkg::*;

  logic                 accept;
  logic [TOTAL_LAT-1:0] vld;
  vec_t                 c0_q, c1_q, c2_q;
  vec_t                 dv0_q [0:2*PROJ_LAT+1];
  vec_t                 dv1_q [0:PROJ_LAT-1];
  vec_t                 dv2_q [0:PROJ_LAT];
  vec_t                 u1_q, u2_q;
  vec_t                 du1_q [0:PROJ_LAT];
  wvec_t                w2_q;
  wvec_t                dw_q [0:PROJ_LAT-1];
  pvec_t                pa, pb, pc;
  vec_t                 qc0, qc1, qc2;
  logic [2:0]           deg;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[TOTAL_LAT-2:0], accept};
    end
  end

  assign done = vld[TOTAL_LAT-1];

  always_ff @(posedge clk) begin
    c0_q <= {m20, m10, m00};
    c1_q <= {m21, m11, m01};
    c2_q <= {m22, m12, m02};
  end

  // projections of columns 1 and 2 onto column 0
  gso_proj u_proj_a (
    .clk(clk),
    .u(c0_q),
    .v(c1_q),
    .p(pa)
  );

  gso_proj u_proj_b (
    .clk(clk),
    .u(c0_q),
    .v(c2_q),
    .p(pb)
  );

  always_ff @(posedge clk) begin
    dv0_q[0] <= c0_q;
    dv1_q[0] <= c1_q;
    dv2_q[0] <= c2_q;
    for (int j = 1; j < 2 * PROJ_LAT + 2; j++) begin
      dv0_q[j] <= dv0_q[j-1];
    end
    for (int j = 1; j < PROJ_LAT; j++) begin
      dv1_q[j] <= dv1_q[j-1];
    end
    for (int j = 1; j < PROJ_LAT + 1; j++) begin
      dv2_q[j] <= dv2_q[j-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      u1_q[i] <= sat32(sxe(dv1_q[PROJ_LAT-1][i]) - sxp(pa[i]));
      w2_q[i] <= sxe(dv2_q[PROJ_LAT-1][i]) - sxp(pb[i]);
    end
  end

  // projection of column 2 onto the new column 1
  gso_proj u_proj_c (
    .clk(clk),
    .u(u1_q),
    .v(dv2_q[PROJ_LAT]),
    .p(pc)
  );

  always_ff @(posedge clk) begin
    dw_q[0]  <= w2_q;
    du1_q[0] <= u1_q;
    for (int j = 1; j < PROJ_LAT; j++) begin
      dw_q[j] <= dw_q[j-1];
    end
    for (int j = 1; j < PROJ_LAT + 1; j++) begin
      du1_q[j] <= du1_q[j-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      u2_q[i] <= sat32(dw_q[PROJ_LAT-1][i] - sxp(pc[i]));
    end
  end

  gso_norm u_norm_0 (
    .clk(clk),
    .u(dv0_q[2*PROJ_LAT+1]),
    .q(qc0),
    .deg(deg[0])
  );

  gso_norm u_norm_1 (
    .clk(clk),
    .u(du1_q[PROJ_LAT]),
    .q(qc1),
    .deg(deg[1])
  );

  gso_norm u_norm_2 (
    .clk(clk),
    .u(u2_q),
    .q(qc2),
    .deg(deg[2])
  );

  assign q00 = qc0[0];
  assign q10 = qc0[1];
  assign q20 = qc0[2];
  assign q01 = qc1[0];
  assign q11 = qc1[1];
  assign q21 = qc1[2];
  assign q02 = qc2[0];
  assign q12 = qc2[1];
  assign q22 = qc2[2];
  assign degenerate = |deg;

endmodule

/* sv/gso_div.sv */
// pipelined restoring divider, one quotient bit per stage
module gso_div #(
  parameter int NW = 94,
  parameter int DW = 62,
  parameter int QW = 41
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);
  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_q [0:QW-2];
  logic [DW-1:0] den_q [0:QW-2];
  logic [QW-1:0] quo_q [0:QW-1];

  for (genvar g = 0; g < QW; g++) begin : g_step
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [CW-1:0] trial;
    logic [CW-1:0] rem_ext;
    logic          take;

    if (g == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign den_in = den_q[g-1];
      assign quo_in = quo_q[g-1];
    end

    assign trial   = CW'(den_in) << (QW - 1 - g);
    assign rem_ext = CW'(rem_in);
    assign take    = rem_ext >= trial;

    always_ff @(posedge clk) begin
      quo_q[g] <= {quo_in[QW-2:0], take};
    end

    // the last stage only needs its quotient bit
    if (g < QW - 1) begin : g_den
      always_ff @(posedge clk) begin
        rem_q[g] <= take ? NW'(rem_ext - trial) : rem_in;
        den_q[g] <= den_in;
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

/* sv/gso_proj.sv */
// projection of a column v onto a column u, one lane per row
module gso_proj (
  input  logic           clk,
  input  gso_pkg::vec_t  u,
  input  gso_pkg::vec_t  v,
  output gso_pkg::pvec_t p
);
  import gso_pkg::*;

  typedef struct packed {
    logic nz;
    logic sat;
    logic neg;
  } pflag_t;

  localparam int DW = 2 * EW - 2;        // |d| and n width
  localparam int NW = DW + EW;           // |d|*|u| width
  localparam int QW = PCAP_LOG + 1;
  localparam int LB = DW / 2;
  localparam int MW = DW - LB + EW;      // partial product width
  localparam int SW = DW + PCAP_LOG + 1; // saturation compare width

  logic signed [2*EW-1:0] uv_q [3];
  logic signed [2*EW-1:0] uu_q [3];
  vec_t                   ua_q, ub_q;
  logic signed [2*EW-1:0] dsum, nsum;
  logic [DW:0]            d_q, dmag_full;
  logic [DW-1:0]          n_q, n3_q, n4_q, dmag;
  logic [EW-1:0]          umag [3];
  logic [MW-1:0]          lo_q [3], hi_q [3];
  logic [NW-1:0]          num_q [3];
  logic                   neg3_q [3], neg4_q [3];
  logic                   nz3_q, nz4_q;
  pflag_t                 flg [3];
  pflag_t                 flg_q [3][0:QW-1];
  logic [QW-1:0]          quo [3];
  logic [QW-1:0]          qmag [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      uv_q[i] <= $signed(u[i]) * $signed(v[i]);
      uu_q[i] <= $signed(u[i]) * $signed(u[i]);
    end
    ua_q <= u;
  end

  // floor divide by four is an arithmetic shift
  always_comb begin
    dsum = (uv_q[0] >>> 2) + (uv_q[1] >>> 2) + (uv_q[2] >>> 2);
    nsum = (uu_q[0] >>> 2) + (uu_q[1] >>> 2) + (uu_q[2] >>> 2);
  end

  always_ff @(posedge clk) begin
    d_q  <= dsum[DW:0];
    n_q  <= nsum[DW-1:0];
    ub_q <= ua_q;
  end

  always_comb begin
    dmag_full = d_q[DW] ? (~d_q + 1'b1) : d_q;
    dmag      = dmag_full[DW-1:0];
    for (int i = 0; i < 3; i++) begin
      umag[i] = ub_q[i][EW-1] ? (~ub_q[i] + 1'b1) : ub_q[i];
    end
  end

  // |d| * |u| split in two halves of |d|
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      lo_q[i]   <= MW'(dmag[LB-1:0]) * MW'(umag[i]);
      hi_q[i]   <= MW'(dmag[DW-1:LB]) * MW'(umag[i]);
      neg3_q[i] <= d_q[DW] ^ ub_q[i][EW-1];
    end
    n3_q  <= n_q;
    nz3_q <= (n_q != '0);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      num_q[i]  <= {hi_q[i], {LB{1'b0}}} + NW'(lo_q[i]);
      neg4_q[i] <= neg3_q[i];
    end
    n4_q  <= n3_q;
    nz4_q <= nz3_q;
  end

  // quotient above the cap iff num >= n * (2^40 + 1)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      flg[i].nz  = nz4_q;
      flg[i].neg = neg4_q[i];
      flg[i].sat = SW'(num_q[i]) >= (SW'({n4_q, {PCAP_LOG{1'b0}}}) + SW'(n4_q));
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    gso_div #(
      .NW(NW),
      .DW(DW),
      .QW(QW)
    ) u_div (
      .clk(clk),
      .num(num_q[l]),
      .den(n4_q),
      .quo(quo[l])
    );
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      flg_q[i][0] <= flg[i];
      for (int j = 1; j < QW; j++) begin
        flg_q[i][j] <= flg_q[i][j-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!flg_q[i][QW-1].nz) begin
        qmag[i] = '0;
      end else if (flg_q[i][QW-1].sat) begin
        qmag[i] = QW'(1) << PCAP_LOG;
      end else begin
        qmag[i] = quo[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p[i] <= flg_q[i][QW-1].neg ? (PW'(0) - PW'(qmag[i])) : PW'(qmag[i]);
    end
  end

endmodule

/* sv/gso_norm.sv */
// scales one column to unit length: squared norm, square root, three lane dividers
module gso_norm (
  input  logic          clk,
  input  gso_pkg::vec_t u,
  output gso_pkg::vec_t q,
  output logic          deg
);
  import gso_pkg::*;

  localparam int SQW = 2 * EW;      // squared norm width
  localparam int RTS = EW;          // square root steps
  localparam int NW  = EW + FRAC;   // |u| << 28
  localparam int QW  = FRAC + 1;

  typedef struct packed {
    logic       zero;
    logic [2:0] neg;
  } nflag_t;

  logic signed [SQW-1:0] sq_full [3];
  logic [SQW-1:0]        sq_q [3];
  logic [SQW-1:0]        s_q;
  logic [SQW-1:0]        rt_n [0:RTS-2];
  logic [SQW-1:0]        rt_res [0:RTS-1];
  vec_t                  ud_q [0:RTS+1];
  logic [EW-1:0]         umag [3];
  logic [QW-1:0]         quo [3];
  nflag_t                nf;
  nflag_t                nf_q [0:QW-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_full[i] = $signed(u[i]) * $signed(u[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= sq_full[i];
    end
    s_q <= sq_q[0] + sq_q[1] + sq_q[2];
  end

  // digit-by-digit integer square root, one result bit per stage
  for (genvar g = 0; g < RTS; g++) begin : g_root
    logic [SQW-1:0] n_in, res_in, rbit;
    logic [SQW:0]   trial;
    logic           ge;

    if (g == 0) begin : g_first
      assign n_in   = s_q;
      assign res_in = '0;
    end else begin : g_next
      assign n_in   = rt_n[g-1];
      assign res_in = rt_res[g-1];
    end

    assign rbit  = SQW'(1) << (SQW - 2 - 2 * g);
    assign trial = (SQW+1)'(res_in) + (SQW+1)'(rbit);
    assign ge    = (SQW+1)'(n_in) >= trial;

    always_ff @(posedge clk) begin
      rt_res[g] <= ge ? ((res_in >> 1) + rbit) : (res_in >> 1);
    end

    if (g < RTS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rt_n[g] <= ge ? (n_in - trial[SQW-1:0]) : n_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    ud_q[0] <= u;
    for (int j = 1; j < RTS + 2; j++) begin
      ud_q[j] <= ud_q[j-1];
    end
  end

  always_comb begin
    nf.zero = (ud_q[RTS+1] == '0);
    for (int i = 0; i < 3; i++) begin
      nf.neg[i] = ud_q[RTS+1][i][EW-1];
      umag[i]   = ud_q[RTS+1][i][EW-1] ? (~ud_q[RTS+1][i] + 1'b1) : ud_q[RTS+1][i];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    gso_div #(
      .NW(NW),
      .DW(EW),
      .QW(QW)
    ) u_div (
      .clk(clk),
      .num({umag[l], {FRAC{1'b0}}}),
      .den(rt_res[RTS-1][EW-1:0]),
      .quo(quo[l])
    );
  end

  always_ff @(posedge clk) begin
    nf_q[0] <= nf;
    for (int j = 1; j < QW; j++) begin
      nf_q[j] <= nf_q[j-1];
    end
  end

  // a zero column stays zero and marks the item degenerate
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (nf_q[QW-1].zero) begin
        q[i] <= '0;
      end else if (nf_q[QW-1].neg[i]) begin
        q[i] <= EW'(0) - EW'(quo[i]);
      end else begin
        q[i] <= EW'(quo[i]);
      end
    end
    deg <= nf_q[QW-1].zero;
  end

endmodule

/* sv/gso_chk.sv */
// port-level checker for the orthonormalizer, bound to the top level
module gso_chk (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] q00,
  input logic [31:0] q01,
  input logic [31:0] q02,
  input logic [31:0] q10,
  input logic [31:0] q11,
  input logic [31:0] q12,
  input logic [31:0] q20,
  input logic [31:0] q21,
  input logic [31:0] q22,
  input logic        degenerate
);
  import gso_pkg::*;

  function automatic logic unit_ok(input logic [31:0] x);
    return ($signed(x) <= 32'sd268435456) && ($signed(x) >= -32'sd268435456);
  endfunction

  // reset drops every beat in flight
  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // each result beat matches an accepted beat a fixed latency back
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT))
    else $error("result strobe without a matching accepted beat");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (unit_ok(q00) && unit_ok(q01) && unit_ok(q02) &&
              unit_ok(q10) && unit_ok(q11) && unit_ok(q12) &&
              unit_ok(q20) && unit_ok(q21) && unit_ok(q22)))
    else $error("orthonormal entry beyond unit magnitude");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |->
      ((q00 == '0 && q10 == '0 && q20 == '0) ||
       (q01 == '0 && q11 == '0 && q21 == '0) ||
       (q02 == '0 && q12 == '0 && q22 == '0)))
    else $error("degenerate flagged with no zero column");

endmodule

bind gram_schmidt_3x3_orthonormalizer_unit gso_chk u_gso_chk (.*);

/* test/gram_schmidt_3x3_orthonormalizer_unit_chk.sv */
// checker for the gram-schmidt unit: predicts each matrix and compares the results
`timescale 1ns / 100ps
module gram_schmidt_3x3_orthonormalizer_unit_chk (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
  input  logic               done,
  input  logic signed [31:0] q00, q01, q02, q10, q11, q12, q20, q21, q22,
  input  logic               degenerate,
  output int                 errors,
  output int                 pending
);
  import gso_pkg::*;

  typedef logic [2:0][63:0] col_t;
  typedef struct {
    elem_t ent [9];
    logic  deg;
  } ortho_t;

  localparam logic [127:0] PROJ_CAP = 128'd1 << PCAP_LOG;

  ortho_t ortho_q [$];

  function automatic longint clamp32(longint x);
    if (x > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (x < -64'sh80000000) return -64'sh80000000;
    return x;
  endfunction

  // projection of v on u, magnitude capped at 2^40
  function automatic col_t project_on(col_t u, col_t v);
    longint d, n, a, b, pl;
    logic [63:0] ad, au;
    logic [127:0] quo;
    col_t p;
    d = 0;
    n = 0;
    for (int i = 0; i < 3; i++) begin
      a = u[i];
      b = v[i];
      d += (a * b) >>> 2;
      n += (a * a) >>> 2;
    end
    for (int i = 0; i < 3; i++) begin
      a = u[i];
      if (n == 0) begin
        p[i] = 0;
      end else begin
        ad = (d < 0) ? -d : d;
        au = (a < 0) ? -a : a;
        quo = ({64'd0, ad} * {64'd0, au}) / {64'd0, n};
        if (quo > PROJ_CAP) quo = PROJ_CAP;
        pl = quo[63:0];
        p[i] = ((d < 0) != (a < 0)) ? -pl : pl;
      end
    end
    return p;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic ortho_t orthonormalize(elem_t ent [9]);
    col_t v [3];
    col_t u [3];
    col_t pa, pb;
    longint a, x;
    logic [63:0] s, len, mg;
    ortho_t r;
    r.deg = 1'b0;
    for (int rr = 0; rr < 3; rr++)
      for (int c = 0; c < 3; c++) begin
        a = $signed(ent[rr*3+c]);
        v[c][rr] = a;
      end
    u[0] = v[0];
    pa = project_on(u[0], v[1]);
    for (int i = 0; i < 3; i++) begin
      x = clamp32(longint'(v[1][i]) - longint'(pa[i]));
      u[1][i] = x;
    end
    pa = project_on(u[0], v[2]);
    pb = project_on(u[1], v[2]);
    for (int i = 0; i < 3; i++) begin
      x = clamp32(longint'(v[2][i]) - longint'(pa[i]) - longint'(pb[i]));
      u[2][i] = x;
    end
    for (int c = 0; c < 3; c++) begin
      s = 0;
      for (int i = 0; i < 3; i++) begin
        a = u[c][i];
        s += a * a;
      end
      if (s == 0) begin
        r.deg = 1'b1;
        for (int i = 0; i < 3; i++) r.ent[i*3+c] = 0;
      end else begin
        len = floor_sqrt(s);
        for (int i = 0; i < 3; i++) begin
          a = u[c][i];
          mg = (((a < 0) ? -a : a) << FRAC) / len;
          x = mg;
          if (a < 0) x = -x;
          r.ent[i*3+c] = x[31:0];
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    elem_t  in_m [9];
    elem_t  got [9];
    ortho_t want;
    int     bad;
    bad = 0;
    if (rst) begin
      errors <= 0;
    end else begin
      if (start && !busy) begin
        in_m = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
        ortho_q.insert(ortho_q.size(), orthonormalize(in_m));
      end
      if (done) begin
        got = '{q00, q01, q02, q10, q11, q12, q20, q21, q22};
        if (ortho_q.size() == 0) begin
          $display("%0t: result beat with no matrix outstanding", $time);
          bad++;
        end else begin
          want = ortho_q.pop_front();
          for (int k = 0; k < 9; k++)
            if (got[k] !== want.ent[k]) begin
              $display("%0t: q%0d%0d expected %0d actual %0d", $time, k / 3, k % 3,
                       $signed(want.ent[k]), $signed(got[k]));
              bad++;
            end
          if (degenerate !== want.deg) begin
            $display("%0t: degenerate expected %0b actual %0b", $time, want.deg,
                     degenerate);
            bad++;
          end
        end
      end
      errors <= errors + bad;
    end
    pending <= ortho_q.size();
  end

endmodule

/* test/gram_schmidt_3x3_orthonormalizer_unit_tb.sv */
// testbench top for the gram-schmidt unit: stimulus, clock, reset and verdict
`timescale 1ns / 100ps
module gram_schmidt_3x3_orthonormalizer_unit_tb;
  import gso_pkg::*;

  localparam int  N_RANDOM = 530;
  localparam int  ONE      = 1 << FRAC;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] m00 = 0, m01 = 0, m02 = 0, m10 = 0, m11 = 0, m12 = 0,
                      m20 = 0, m21 = 0, m22 = 0;
  logic done;
  logic signed [31:0] q00, q01, q02, q10, q11, q12, q20, q21, q22;
  logic degenerate;
  int errors;
  int pending;
  bit burst;

  gram_schmidt_3x3_orthonormalizer_unit u_top (.*);
  gram_schmidt_3x3_orthonormalizer_unit_chk u_chk (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // one matrix beat, row-major, after a random gap outside bursts
  task automatic send_matrix(input elem_t e [9]);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    {m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
      {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic elem_t near(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic send_fill(input elem_t val);
    elem_t e [9];
    foreach (e[k]) e[k] = val;
    send_matrix(e);
  endtask

  initial begin
    elem_t e [9];
    int mode;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: zeros, constants at the extremes, identity, tiny, small, zero and parallel columns
    send_fill(0);
    send_fill(32'h7FFFFFFF);
    send_fill(32'h80000000);
    send_fill(32'hFFFFFFFF);
    send_fill(1);
    e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
    send_matrix(e);
    e = '{-ONE, 0, 0, 0, 0, ONE, 0, ONE, 0};
    send_matrix(e);
    // tiny first column: projection taken as zero
    e = '{1, ONE, 5, -1, 3, ONE, 1, -ONE, 7};
    send_matrix(e);
    // small first column against huge others
    e = '{2, 32'h7FFFFFFF, 32'h80000000, 2, 32'h7FFFFFFF, 32'h7FFFFFFF,
          0, 32'h80000000, 32'h7FFFFFFF};
    send_matrix(e);
    e = '{3, 32'h80000000, 1, 0, 32'h80000000, 32'h7FFFFFFF, -3, 32'h7FFFFFFF, 0};
    send_matrix(e);
    // zero middle column
    e = '{ONE, 0, ONE, ONE, 0, -ONE, 0, 0, ONE};
    send_matrix(e);
    // dependent columns
    e = '{ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE};
    send_matrix(e);
    e = '{ONE, -ONE, 0, ONE, -ONE, ONE, 0, 0, ONE};
    send_matrix(e);
    e = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0, 0, 0};
    send_matrix(e);
    e = '{0, 0, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h80000000};
    send_matrix(e);
    e = '{-1, 1, 32'h55555555, 1, -1, 32'hAAAAAAAA, 0, 1, 32'h12345678};
    send_matrix(e);
    for (int it = 0; it < N_RANDOM; it++) begin
      if (it % 40 == 0) burst = ($urandom_range(0, 2) == 0);
      mode = $urandom_range(0, 9);
      foreach (e[k]) e[k] = $urandom;
      case (mode)
        0, 1: ;
        2, 3, 4: foreach (e[k]) e[k] = near(ONE);
        5: foreach (e[k]) e[k] = near(4);
        6: begin
          // near-dependent columns
          foreach (e[k]) if (k % 3 == 0) e[k] = near(2 * ONE);
          for (int rr = 0; rr < 3; rr++) begin
            e[rr*3+1] = (e[rr*3] >>> $urandom_range(0, 3)) + near(4);
            e[rr*3+2] = e[rr*3] + e[rr*3+1] + near(2);
          end
        end
        7: for (int rr = 0; rr < 3; rr++) e[rr*3 + $urandom_range(0, 2)] = 0;
        8: begin
          // one column small against wide others
          mode = $urandom_range(0, 2);
          for (int rr = 0; rr < 3; rr++) e[rr*3+mode] = near(3);
        end
        default: foreach (e[k]) e[k] = near(8 * ONE - 1);
      endcase
      send_matrix(e);
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (TOTAL_LAT + 20) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* gram_schmidt_3x3_orthonormalizer_unit.f */
sv/gso_pkg.sv
sv/gso_div.sv
sv/gso_proj.sv
sv/gso_norm.sv
sv/gram_schmidt_3x3_orthonormalizer_unit.sv
sv/gso_chk.sv
test/gram_schmidt_3x3_orthonormalizer_unit_chk.sv
test/gram_schmidt_3x3_orthonormalizer_unit_tb.sv
